// ===== hdl/pbc_pkg.sv =====
// Package for the packed BCD codec: transaction payload types, operation codes
// and the fixed widths and constants that the codec cells use.
// No dependencies.
package pbc_pkg;

  localparam int BIN_W    = 32;
  localparam int BCD_W    = 24;
  localparam int VALUE_W  = 21;
  localparam int BYTE_W   = 8;
  localparam int NIBBLE_W = 4;

  // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x
  localparam logic [BIN_W-1:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int DIV100_SHIFT = 37;
  localparam int QUOT_W       = 2 * BIN_W - DIV100_SHIFT;

  // r / 10 == (r * DIV10_MAGIC) >> DIV10_SHIFT for r below 100
  localparam int REM_W        = 7;
  localparam int DIV10_PROD_W = 15;
  localparam logic [DIV10_PROD_W-1:0] DIV10_MAGIC = 15'd205;
  localparam int DIV10_SHIFT  = 11;

  localparam logic [BIN_W-1:0]    BYTE_RADIX  = 32'd100;
  localparam logic [REM_W-1:0]    DIGIT_RADIX = 7'd10;
  localparam logic [VALUE_W-1:0]  DEC_BYTE_WEIGHT = 21'd100;
  localparam logic [VALUE_W-1:0]  DEC_TEN_WEIGHT  = 21'd10;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BCD_W-1:0] bcd_word;
    logic [BIN_W-1:0] binary_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic [BCD_W-1:0]   bcd_out;
  } out_item_t;

endpackage

// ===== hdl/pbc_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is a parameter; the codec uses the structs of pbc_pkg.
interface pbc_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== hdl/pbc_cell.sv =====
// One byte cell of the codec chain: folds one packed BCD byte into the decode
// accumulator and splits two decimal digits off the encode value. Uses pbc_pkg.
module pbc_cell
  import pbc_pkg::*;
#(
  parameter int WORD_W = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  op_t                op_in,
  input  logic [WORD_W-1:0]  word_in,
  input  logic [BIN_W-1:0]   value_in,
  input  logic [VALUE_W-1:0] acc_in,
  input  logic [WORD_W-1:0]  bcd_in,
  output logic               valid_out,
  output op_t                op_out,
  output logic [WORD_W-1:0]  word_out,
  output logic [BIN_W-1:0]   value_out,
  output logic [VALUE_W-1:0] acc_out,
  output logic [WORD_W-1:0]  bcd_out
);

  logic [BYTE_W-1:0]   dec_byte;
  logic [VALUE_W-1:0]  acc_next;
  logic [2*BIN_W-1:0]  prod;

  logic                a_valid;
  op_t                 a_op;
  logic [WORD_W-1:0]   a_word;
  logic [BIN_W-1:0]    a_value;
  logic [QUOT_W-1:0]   a_quot;
  logic [VALUE_W-1:0]  a_acc;
  logic [WORD_W-1:0]   a_bcd;

  logic [BIN_W-1:0]        rem_full;
  logic [REM_W-1:0]        rem;
  logic [DIV10_PROD_W-1:0] tens_prod;
  logic [NIBBLE_W-1:0]     tens;
  logic [REM_W-1:0]        units_full;
  logic [NIBBLE_W-1:0]     units;
  logic [WORD_W-1:0]       bcd_next;

  // stage a: decode step and reciprocal multiply
  always_comb begin
    dec_byte = word_in[WORD_W-1 -: BYTE_W];
    if (op_in == OP_DECODE) begin
      acc_next = acc_in * DEC_BYTE_WEIGHT
               + VALUE_W'(dec_byte[BYTE_W-1:NIBBLE_W]) * DEC_TEN_WEIGHT
               + VALUE_W'(dec_byte[NIBBLE_W-1:0]);
    end else begin
      acc_next = acc_in;
    end
    prod = (2*BIN_W)'(value_in) * (2*BIN_W)'(DIV100_MAGIC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op    <= op_in;
      a_word  <= word_in << BYTE_W;
      a_value <= value_in;
      a_quot  <= prod[2*BIN_W-1:DIV100_SHIFT];
      a_acc   <= acc_next;
      a_bcd   <= bcd_in;
    end
  end

  // stage b: remainder, digit split, pack into the top byte
  always_comb begin
    rem_full   = a_value - BIN_W'(a_quot) * BYTE_RADIX;
    rem        = rem_full[REM_W-1:0];
    tens_prod  = DIV10_PROD_W'(rem) * DIV10_MAGIC;
    tens       = tens_prod[DIV10_SHIFT +: NIBBLE_W];
    units_full = rem - REM_W'(tens) * DIGIT_RADIX;
    units      = units_full[NIBBLE_W-1:0];
    if (a_op == OP_ENCODE) begin
      bcd_next = (a_bcd >> BYTE_W) | (WORD_W'({tens, units}) << (WORD_W - BYTE_W));
    end else begin
      bcd_next = a_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_out    <= a_op;
      word_out  <= a_word;
      value_out <= BIN_W'(a_quot);
      acc_out   <= a_acc;
      bcd_out   <= bcd_next;
    end
  end

endmodule

// ===== hdl/packed_bcd_codec_top.sv =====
// Packed BCD codec top level: a chain of byte cells converting between binary
// and big-endian packed BCD. Uses pbc_pkg, pbc_stream_if and pbc_cell.
//
//   channel  direction  payload
//   req      sink       op, bcd_word, binary_value
//   rsp      source     value_out, bcd_out
//
// The chain holds (NUM_DIGITS + 1) / 2 byte cells, three at the default size; each
// byte cell holds two register stages (reciprocal multiply, then digit split).
// One transaction is taken per cycle while rsp is not stalled; the cells are fully pipelined.
// Synchronous reset clears the valid bits of every stage.
// A stalled rsp freezes the whole chain and drops req.ready in the same cycle.
module packed_bcd_codec_top
  import pbc_pkg::*;
#(
  parameter int NUM_DIGITS = 6
) (
  input logic          clk,
  input logic          rst,
  pbc_stream_if.sink   req,
  pbc_stream_if.source rsp
);

  localparam int BcdBytes = (NUM_DIGITS + 1) / 2;
  localparam int WordW    = BcdBytes * BYTE_W;

  logic               en;
  logic               valid_chain [0:BcdBytes];
  op_t                op_chain    [0:BcdBytes];
  logic [WordW-1:0]   word_chain  [0:BcdBytes];
  logic [BIN_W-1:0]   value_chain [0:BcdBytes];
  logic [VALUE_W-1:0] acc_chain   [0:BcdBytes];
  logic [WordW-1:0]   bcd_chain   [0:BcdBytes];

  assign en        = !valid_chain[BcdBytes] || rsp.ready;
  assign req.ready = en;

  assign valid_chain[0] = req.valid;
  assign op_chain[0]    = req.payload.op;
  assign word_chain[0]  = WordW'(req.payload.bcd_word);
  assign value_chain[0] = req.payload.binary_value;
  assign acc_chain[0]   = '0;
  assign bcd_chain[0]   = '0;

  for (genvar i = 0; i < BcdBytes; i++) begin : g_cell
    pbc_cell #(
      .WORD_W(WordW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (valid_chain[i]),
      .op_in    (op_chain[i]),
      .word_in  (word_chain[i]),
      .value_in (value_chain[i]),
      .acc_in   (acc_chain[i]),
      .bcd_in   (bcd_chain[i]),
      .valid_out(valid_chain[i+1]),
      .op_out   (op_chain[i+1]),
      .word_out (word_chain[i+1]),
      .value_out(value_chain[i+1]),
      .acc_out  (acc_chain[i+1]),
      .bcd_out  (bcd_chain[i+1])
    );
  end

  assign rsp.valid             = valid_chain[BcdBytes];
  assign rsp.payload.value_out = acc_chain[BcdBytes];
  assign rsp.payload.bcd_out   = BCD_W'(bcd_chain[BcdBytes]);

`ifndef SYNTHESIS
  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("req accepted while rsp stalled");

  a_empty_takes_req: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("req held off with empty output stage");

  a_decode_no_bcd: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && op_chain[BcdBytes] == OP_DECODE |-> rsp.payload.bcd_out == '0)
    else $error("decode result carries BCD digits");

  a_encode_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && op_chain[BcdBytes] == OP_ENCODE |-> rsp.payload.value_out == '0)
    else $error("encode result carries a binary value");
`endif

endmodule
